### sv/csht_pkg.sv
// Shared types and codes for the chained scatter hash table.
// Depends on nothing; used by the top level, the remainder unit and the testbench.
package csht_pkg;

  localparam int unsigned SLOTS_DEF = 1024;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned DATA_W    = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic [1:0] STAT_HIT    = 2'd0;
  localparam logic [1:0] STAT_MISS   = 2'd1;
  localparam logic [1:0] STAT_INSERT = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

### sv/chained_scatter_hash_table_top.sv
// Top level of the chained scatter hash table: sequencer, slot store, remainder unit.
// Depends on csht_pkg, csht_mod and csht_mem.
//
// A coalesced hash table of SLOTS entries. Issue a get or set transaction by
// raising start while busy is low; busy stays high until the cycle in which the
// single result transaction is shown on rsp_o with result_valid_o, so the next
// transaction can be taken at the same edge that takes the result.
// The receiver cannot stall: sample rsp_o whenever result_valid_o is high.
// After reset the block first sweeps the slot store, one slot per cycle, so
// busy is high until the sweep is done and only then is a transaction taken.
// Every step runs through one slot-store read port (a read is issued, then
// checked) and one shared remainder unit. A get or set finds its home slot and
// walks its chain link by link; a set that misses and finds its home slot used
// scans down for a free slot, checks it, looks up the occupant's home, walks
// the occupant's chain when the occupant must move, and makes two writes; a
// set that finds the table full ends at the scan. A SLOTS that is not a power
// of two makes each remainder take the reciprocal path (one or two per set).
module chained_scatter_hash_table_top #(
  parameter int unsigned SLOTS = csht_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  csht_pkg::req_t req_i,
  output logic           busy,
  output logic           result_valid_o,
  output csht_pkg::rsp_t rsp_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = IW + 1;

  typedef struct packed {
    logic                        used;
    logic [LW-1:0]               link;
    logic [csht_pkg::KEY_W-1:0]  key;
    logic [csht_pkg::DATA_W-1:0] data;
  } row_t;

  localparam int unsigned RW = $bits(row_t);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HOME, ST_FIND_RD, ST_FIND_CHK, ST_SCAN_RD, ST_SCAN_CHK,
    ST_OMP, ST_WALK_RD, ST_WALK_CHK, ST_WR_FREE, ST_WR_HOME
  } state_e;

  state_e         state_q;
  logic [IW-1:0]  clr_q;
  logic [LW-1:0]  fs_q;        // free scan pointer, SLOTS at reset
  logic [IW-1:0]  cur_q;       // slot being walked
  logic [IW-1:0]  home_idx_q;
  logic [IW-1:0]  fr_q;
  row_t           home_q;
  logic           first_q;     // next chain check is the home slot
  logic           foreign_q;
  csht_pkg::req_t req_q;
  logic           res_vld_q;
  csht_pkg::rsp_t rsp_q;

  // slot store and remainder unit hookups
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;
  row_t          rd;
  row_t          home_row;

  logic                       mod_start;
  logic [csht_pkg::KEY_W-1:0] mod_key;
  logic                       mod_done;
  logic [IW-1:0]              mod_rem;

  logic          link_none;
  logic          accept;

  assign rd        = row_t'(mem_rdata);
  assign home_row  = first_q ? rd : home_q;
  assign link_none = (rd.link >= LW'(SLOTS));
  assign accept    = (state_q == ST_IDLE) && start;

  assign mem_raddr = (state_q == ST_SCAN_RD) ? IW'(fs_q - LW'(1)) : cur_q;

  assign mod_start = accept || ((state_q == ST_SCAN_CHK) && !rd.used);
  assign mod_key   = (state_q == ST_IDLE) ? req_i.key : home_q.key;

  // write port: one row per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = rd;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{used: 1'b0, link: '1, key: '0, data: '0};
      end
      ST_FIND_CHK: begin
        if (req_q.opcode == csht_pkg::OP_SET) begin
          if (rd.used && (rd.key == req_q.key)) begin
            mem_we         = 1'b1;
            mem_waddr      = cur_q;
            mem_wdata      = rd;
            mem_wdata.data = req_q.value;
          end else if (link_none && !home_row.used) begin
            mem_we    = 1'b1;
            mem_waddr = home_idx_q;
            mem_wdata = '{used: 1'b1, link: '1, key: req_q.key, data: req_q.value};
          end
        end
      end
      ST_WALK_CHK: begin
        if (!link_none && (rd.link[IW-1:0] == home_idx_q)) begin
          mem_we         = 1'b1;
          mem_waddr      = cur_q;
          mem_wdata      = rd;
          mem_wdata.link = LW'(fr_q);
        end
      end
      ST_WR_FREE: begin
        mem_we    = 1'b1;
        mem_waddr = fr_q;
        if (foreign_q) begin
          mem_wdata = '{used: 1'b1, link: home_q.link, key: home_q.key, data: home_q.data};
        end else begin
          mem_wdata = '{used: 1'b1, link: home_q.link, key: req_q.key, data: req_q.value};
        end
      end
      ST_WR_HOME: begin
        mem_we    = 1'b1;
        mem_waddr = home_idx_q;
        if (foreign_q) begin
          mem_wdata = '{used: 1'b1, link: '1, key: req_q.key, data: req_q.value};
        end else begin
          mem_wdata      = home_q;
          mem_wdata.link = LW'(fr_q);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      fs_q      <= LW'(SLOTS);
      first_q   <= 1'b0;
      foreign_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IW'(SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q     <= req_i;
            foreign_q <= 1'b0;
            state_q   <= ST_HOME;
          end
        end
        ST_HOME: begin
          if (mod_done) begin
            home_idx_q <= mod_rem;
            cur_q      <= mod_rem;
            first_q    <= 1'b1;
            state_q    <= ST_FIND_RD;
          end
        end
        ST_FIND_RD: begin
          state_q <= ST_FIND_CHK;
        end
        ST_FIND_CHK: begin
          first_q <= 1'b0;
          if (first_q) begin
            home_q <= rd;
          end
          if (rd.used && (rd.key == req_q.key)) begin
            res_vld_q        <= 1'b1;
            rsp_q.status     <= csht_pkg::STAT_HIT;
            rsp_q.read_value <= (req_q.opcode == csht_pkg::OP_GET) ? rd.data : '0;
            state_q          <= ST_IDLE;
          end else if (!link_none) begin
            cur_q   <= rd.link[IW-1:0];
            state_q <= ST_FIND_RD;
          end else if (req_q.opcode == csht_pkg::OP_GET) begin
            res_vld_q        <= 1'b1;
            rsp_q.status     <= csht_pkg::STAT_MISS;
            rsp_q.read_value <= '0;
            state_q          <= ST_IDLE;
          end else if (!home_row.used) begin
            res_vld_q        <= 1'b1;
            rsp_q.status     <= csht_pkg::STAT_INSERT;
            rsp_q.read_value <= '0;
            state_q          <= ST_IDLE;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          if (fs_q == '0) begin
            res_vld_q        <= 1'b1;
            rsp_q.status     <= csht_pkg::STAT_FULL;
            rsp_q.read_value <= '0;
            state_q          <= ST_IDLE;
          end else begin
            fs_q    <= fs_q - LW'(1);
            state_q <= ST_SCAN_CHK;
          end
        end
        ST_SCAN_CHK: begin
          if (!rd.used) begin
            fr_q    <= fs_q[IW-1:0];
            state_q <= ST_OMP;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_OMP: begin
          if (mod_done) begin
            if (mod_rem == home_idx_q) begin
              state_q <= ST_WR_FREE;
            end else begin
              foreign_q <= 1'b1;
              cur_q     <= mod_rem;
              state_q   <= ST_WALK_RD;
            end
          end
        end
        ST_WALK_RD: begin
          state_q <= ST_WALK_CHK;
        end
        ST_WALK_CHK: begin
          // stop at chain end or after repairing the link into the home slot
          if (link_none || (rd.link[IW-1:0] == home_idx_q)) begin
            state_q <= ST_WR_FREE;
          end else begin
            cur_q   <= rd.link[IW-1:0];
            state_q <= ST_WALK_RD;
          end
        end
        ST_WR_FREE: begin
          state_q <= ST_WR_HOME;
        end
        ST_WR_HOME: begin
          res_vld_q        <= 1'b1;
          rsp_q.status     <= csht_pkg::STAT_INSERT;
          rsp_q.read_value <= '0;
          state_q          <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign rsp_o          = rsp_q;

  csht_mem #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    (RW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  csht_mod #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (mod_key),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // one result per transaction, never back to back
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("accepted transaction did not raise busy");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != csht_pkg::STAT_HIT)) |-> (rsp_o.read_value == '0))
    else $error("nonzero read value on a result that is not a hit");

  a_no_result_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !result_valid_o)
    else $error("result during the clearing sweep");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q <= LW'(SLOTS))
    else $error("free scan pointer above table top");

endmodule

### sv/csht_mod.sv
// Remainder unit: key modulo SLOTS, shared by home-slot lookups.
// Depends on csht_pkg. Mask for a power-of-two SLOTS, else a registered reciprocal multiply.
module csht_mod #(
  parameter int unsigned SLOTS = csht_pkg::SLOTS_DEF,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [csht_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [IW-1:0]             rem_o
);

  logic          done_q;
  logic [IW-1:0] rem_q;

  assign done_o = done_q;
  assign rem_o  = rem_q;

  if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= key_i[IW-1:0];
      end
    end
  end else begin : g_recip
    // quotient = (key * ceil(2^SH / SLOTS)) >> SH, exact for keys of up to 31 bits, as RECIP is 32 bits wide
    localparam int unsigned KW    = csht_pkg::KEY_W;
    localparam int unsigned SH    = KW + $clog2(SLOTS);
    localparam int unsigned PW    = KW + 32;
    localparam logic [31:0] RECIP =
      32'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    logic          s1_q;
    logic          s2_q;
    logic [KW-1:0] key_q;
    logic [KW-1:0] quo_q;
    logic [PW-1:0] prod;
    logic [IW-1:0] qd_low;

    assign prod   = PW'(key_q) * PW'(RECIP);
    // remainder is below SLOTS, so only the low IW bits of quotient * SLOTS matter
    assign qd_low = quo_q[IW-1:0] * IW'(SLOTS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s1_q   <= start_i;
        s2_q   <= s1_q;
        done_q <= s2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end
      if (s1_q) begin
        quo_q <= KW'(prod >> SH);
      end
      if (s2_q) begin
        rem_q <= key_q[IW-1:0] - qd_low;
      end
    end
  end

endmodule

### sv/csht_mem.sv
// Slot store: one write port, one read port with registered read data.
// Depends on nothing; row layout is set by the instantiating module.
module csht_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 75
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb.sv
// Self-checking testbench for chained_scatter_hash_table_top.
// Directed, random and fill-to-full traffic; depends on csht_pkg and the RTL of the block.
// A built-in predictor checks every result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS          = int'(csht_pkg::SLOTS_DEF);
  localparam int KEY_W          = int'(csht_pkg::KEY_W);
  localparam int DATA_W         = int'(csht_pkg::DATA_W);
  localparam int NO_LINK        = -1;     // end of a collision chain
  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES   = 32;
  localparam int MAX_REPORTS    = 10;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  logic           result_valid_o;
  csht_pkg::req_t req_i;
  csht_pkg::rsp_t rsp_o;

  chained_scatter_hash_table_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_i         (req_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the hash table. Keys and data are only read where the
  // slot is marked used, same as the hardware.
  // ---------------------------------------------------------------------------
  bit                hm_used [SLOTS];
  logic [KEY_W-1:0]  hm_key  [SLOTS];
  logic [DATA_W-1:0] hm_data [SLOTS];
  int                hm_next [SLOTS];
  int                hm_scan;          // downward free-slot pointer

  csht_pkg::rsp_t    pending_rsp_q[$]; // results owed by the block, oldest first
  logic [KEY_W-1:0]  stored_keys[$];   // keys known to be in the table
  int                slots_filled;
  int                mismatch_count;
  int                stall_cycles;
  bit                gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int home_slot(logic [KEY_W-1:0] key);
    return int'({1'b0, key} % SLOTS);
  endfunction

  // Chain walk from the home slot; every chain holds only keys of that home.
  function automatic int find_slot(logic [KEY_W-1:0] key);
    int s;
    s = home_slot(key);
    for (int steps = 0; steps < SLOTS; steps++) begin
      if (hm_used[s] && hm_key[s] == key) return s;
      if (hm_next[s] == NO_LINK) return NO_LINK;
      s = hm_next[s];
    end
    return NO_LINK;
  endfunction

  // Applies one transaction to the shadow table and returns the result the
  // block must produce for it.
  function automatic csht_pkg::rsp_t predict_hash_op(csht_pkg::req_t r);
    csht_pkg::rsp_t res;
    int   hit;
    int   home;
    int   fr;
    int   s;
    int   n;
    res.status     = csht_pkg::STAT_HIT;
    res.read_value = '0;
    hit = find_slot(r.key);
    if (r.opcode == csht_pkg::OP_GET) begin
      if (hit != NO_LINK) res.read_value = hm_data[hit];
      else res.status = csht_pkg::STAT_MISS;
      return res;
    end
    if (hit != NO_LINK) begin
      hm_data[hit] = r.value;
      return res;
    end
    home = home_slot(r.key);
    res.status = csht_pkg::STAT_INSERT;
    if (!hm_used[home]) begin
      hm_used[home] = 1'b1;
      hm_key[home]  = r.key;
      hm_data[home] = r.value;
      hm_next[home] = NO_LINK;
      return res;
    end
    fr = NO_LINK;
    while (hm_scan > 0 && fr == NO_LINK) begin
      hm_scan--;
      if (!hm_used[hm_scan]) fr = hm_scan;
    end
    if (fr == NO_LINK) begin
      res.status = csht_pkg::STAT_FULL;
      return res;
    end
    hm_used[fr] = 1'b1;
    if (home_slot(hm_key[home]) == home) begin
      // occupant is at home: new key goes right behind it
      hm_key[fr]    = r.key;
      hm_data[fr]   = r.value;
      hm_next[fr]   = hm_next[home];
      hm_next[home] = fr;
    end else begin
      // foreign occupant: relink its predecessor to the free slot, then move it
      s = home_slot(hm_key[home]);
      for (int steps = 0; steps < SLOTS; steps++) begin
        n = hm_next[s];
        if (n == NO_LINK) break;
        if (n == home) begin
          hm_next[s] = fr;
          break;
        end
        s = n;
      end
      hm_key[fr]    = hm_key[home];
      hm_data[fr]   = hm_data[home];
      hm_next[fr]   = hm_next[home];
      hm_key[home]  = r.key;
      hm_data[home] = r.value;
      hm_next[home] = NO_LINK;
    end
    return res;
  endfunction

  // New keys: half spread over the whole table, the rest piled onto the lowest
  // and highest homes so chains grow and relocated keys get evicted again.
  function automatic logic [KEY_W-1:0] fresh_key();
    int unsigned upper;
    int unsigned home;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) home = $urandom_range(0, SLOTS - 1);
    else if (pick < 75) home = $urandom_range(0, 15);
    else home = $urandom_range(SLOTS - 16, SLOTS - 1);
    upper = $urandom() & 32'h7FFF_FFFF;
    return KEY_W'(upper / SLOTS * SLOTS + home);
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising-edge time step; returns in the time step of the
  // edge that accepted the transaction, with start still high, so that a
  // following call can keep start up without lowering it in between.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic opc, input logic [KEY_W-1:0] key,
                         input logic [DATA_W-1:0] value);
    csht_pkg::req_t r;
    csht_pkg::rsp_t want;
    r.opcode = opc;
    r.key    = key;
    r.value  = value;
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    want = predict_hash_op(r);
    pending_rsp_q.push_back(want);
    if (want.status == csht_pkg::STAT_INSERT) begin
      slots_filled++;
      stored_keys.push_back(key);
    end
  endtask

  // Drop start and hold off until the block has returned every result.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Empty-table miss, key and value extremes, update, both kinds of collision
  // (own occupant and evicted foreign occupant, with the predecessor at the
  // head and in the middle of the chain), and a get whose value is ignored.
  task automatic test_directed();
    gaps_on = 1'b1;
    send_op(csht_pkg::OP_GET, '0, 32'hDEAD_BEEF);
    send_op(csht_pkg::OP_SET, '0, 32'h0000_0000);
    send_op(csht_pkg::OP_GET, '0, '0);
    send_op(csht_pkg::OP_SET, '0, 32'hFFFF_FFFF);
    send_op(csht_pkg::OP_GET, '0, '0);
    send_op(csht_pkg::OP_SET, KEY_W'(5), 32'h0000_000A);
    send_op(csht_pkg::OP_SET, KEY_W'(5 + SLOTS), 32'h0000_000B);      // into top free slot
    send_op(csht_pkg::OP_SET, KEY_W'(5 + 2 * SLOTS), 32'h0000_000C);  // next free slot
    send_op(csht_pkg::OP_SET, '1, 32'h1234_5678);                     // evicts from top slot
    send_op(csht_pkg::OP_SET, KEY_W'(SLOTS - 2), 32'h8765_4321);      // evicts again
    send_op(csht_pkg::OP_GET, KEY_W'(5 + SLOTS), '0);
    send_op(csht_pkg::OP_GET, KEY_W'(5 + 2 * SLOTS), '0);
    send_op(csht_pkg::OP_GET, '1, '0);
    send_op(csht_pkg::OP_GET, KEY_W'(SLOTS - 2), '0);
    send_op(csht_pkg::OP_GET, KEY_W'(5), '0);
    send_op(csht_pkg::OP_GET, KEY_W'(5 + 3 * SLOTS), '0);             // miss after full walk
    send_op(csht_pkg::OP_GET, '1, 32'hFFFF_FFFF);
    send_op(csht_pkg::OP_SET, '1, 32'h5555_AAAA);
    send_op(csht_pkg::OP_GET, '1, 32'hAAAA_5555);
    send_op(csht_pkg::OP_GET, KEY_W'(SLOTS - 1), '0);                 // same home, other key
  endtask

  // Mixed gets and sets; the first quiet_items go back to back.
  task automatic test_random_ops(input int count, input int quiet_items);
    int pick;
    for (int i = 0; i < count; i++) begin
      gaps_on = (i >= quiet_items);
      pick = $urandom_range(0, 99);
      if (pick < 40 || stored_keys.size() == 0) begin
        send_op(csht_pkg::OP_SET, fresh_key(), $urandom());
      end else if (pick < 65) begin
        send_op(csht_pkg::OP_SET, known_key(), $urandom());
      end else if (pick < 90) begin
        send_op(csht_pkg::OP_GET, known_key(), $urandom());
      end else begin
        send_op(csht_pkg::OP_GET, fresh_key(), $urandom());
      end
    end
  endtask

  // Let the block settle, then insert until no slot is left and keep
  // inserting so the table-full answer shows up repeatedly.
  task automatic test_fill_to_full();
    wait_drained();
    gaps_on = 1'b1;
    while (slots_filled < SLOTS) send_op(csht_pkg::OP_SET, fresh_key(), $urandom());
    for (int i = 0; i < 50; i++) send_op(csht_pkg::OP_SET, fresh_key(), $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is a result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    csht_pkg::rsp_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected result transaction: status %0d value %h",
                   $realtime, rsp_o.status, rsp_o.read_value);
        mismatch_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.read_value !== want.read_value) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch: status exp %0d got %0d, read_value exp %h got %h",
                     $realtime, want.status, rsp_o.status, want.read_value, rsp_o.read_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** chained_scatter_hash_table_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence. The block sweeps its store after reset with busy high,
  // which the sender simply waits out.
  // ---------------------------------------------------------------------------
  initial begin
    start          = 1'b0;
    req_i          = '0;
    rst_ni         = 1'b0;
    gaps_on        = 1'b0;
    slots_filled   = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      hm_used[i] = 1'b0;
      hm_key[i]  = '0;
      hm_data[i] = '0;
      hm_next[i] = NO_LINK;
    end
    hm_scan = SLOTS;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_ops(800, 200);
    test_fill_to_full();
    test_random_ops(350, 0);   // traffic against the full table

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("** chained_scatter_hash_table_top: PASSED **");
    end else begin
      $display("** chained_scatter_hash_table_top: FAILED **");
    end
    $finish;
  end

endmodule

### chained_scatter_hash_table_top.f
sv/csht_pkg.sv
sv/csht_mod.sv
sv/csht_mem.sv
sv/chained_scatter_hash_table_top.sv
tb/tb.sv
